### design/sba_pkg.sv
// Shared constants, codes and controller/datapath types for the spectrum bin resampler.
package sba_pkg;

    localparam int BIN_COUNT = 64;
    localparam int BIN_IDX_W = 6;
    localparam int NB_W      = 7;
    localparam int WL_W      = 20;
    localparam int V_W       = 24;
    localparam int ACC_W     = 48;
    localparam int POS_W     = 28;
    localparam int QUO_W     = 49;
    localparam int CRV_W     = 27;

    localparam logic [WL_W-1:0] START_RESET = 20'd97280;
    localparam logic [WL_W-1:0] WIDTH_RESET = 20'd1600;

    localparam logic signed [QUO_W-1:0] V_MAX = 49'sd8388607;
    localparam logic signed [QUO_W-1:0] V_MIN = -49'sd8388608;

    typedef enum logic {
        CFG_START = 1'b0,
        CFG_WIDTH = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        DIV_CURVE_A,
        DIV_CURVE_B,
        DIV_AVG
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIN,
        S_HI,
        S_CLIP,
        S_PIECE,
        S_DIVA,
        S_DIVB,
        S_ACC,
        S_TEST,
        S_DIVAVG,
        S_EMIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic     in_ready;
        logic     load_in;
        logic     calc_lo;
        logic     calc_hi;
        logic     calc_cb;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_ia;
        logic     take_ib;
        logic     acc_add;
        logic     take_avg;
        logic     emit_load;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic bins_done;
        logic piece_ok;
        logic emit_cond;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

### design/sba_if.sv
// Valid/ready channel interfaces for input points and output bins.
interface sba_in_if;
    logic                               valid;
    logic                               ready;
    logic [sba_pkg::WL_W-1:0]           wavelength;
    logic signed [sba_pkg::V_W-1:0]     sample_value;
    logic                               last_point;

    modport source (output valid, output wavelength, output sample_value,
                    output last_point, input ready);
    modport sink (input valid, input wavelength, input sample_value,
                  input last_point, output ready);
endinterface

interface sba_out_if;
    logic                               valid;
    logic                               ready;
    logic [sba_pkg::BIN_IDX_W-1:0]      bin_index;
    logic signed [sba_pkg::V_W-1:0]     bin_average;
    logic                               last_bin;

    modport source (output valid, output bin_index, output bin_average,
                    output last_bin, input ready);
    modport sink (input valid, input bin_index, input bin_average,
                  input last_bin, output ready);
endinterface

### design/sba_div.sv
// Bit-serial signed floor divider with an unsigned divisor.
module sba_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [sba_pkg::ACC_W-1:0]   i_num,
    input  logic [sba_pkg::WL_W:0]             i_den,
    output logic                               o_busy,
    output logic                               o_done,
    output logic signed [sba_pkg::QUO_W-1:0]   o_quo
);
    localparam int STEPS = sba_pkg::ACC_W;

    logic                        r_busy;
    logic                        r_done;
    logic [5:0]                  r_cnt;
    logic                        r_neg;
    logic [sba_pkg::ACC_W-1:0]   r_quo;
    logic [sba_pkg::WL_W:0]      r_rem;
    logic [sba_pkg::WL_W:0]      r_den;
    logic [sba_pkg::WL_W:0]      n_rem;
    logic [sba_pkg::WL_W+1:0]    sh;
    logic                        ge;
    logic [sba_pkg::ACC_W-1:0]   mag_in;
    logic signed [sba_pkg::QUO_W-1:0] mag;

    assign mag_in = i_num[sba_pkg::ACC_W-1] ? (~i_num + 1'b1) : i_num;
    assign sh     = {r_rem, r_quo[sba_pkg::ACC_W-1]};
    assign ge     = sh >= {1'b0, r_den};
    assign n_rem  = ge ? (sba_pkg::WL_W+1)'(sh - {1'b0, r_den}) : sh[sba_pkg::WL_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag_in;
            r_rem <= '0;
            r_neg <= i_num[sba_pkg::ACC_W-1];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[sba_pkg::ACC_W-2:0], ge};
        end
    end

    // Floor rounding: a negative dividend with a remainder steps one further down.
    assign mag    = signed'({1'b0, r_quo});
    assign o_quo  = r_neg ? (-mag - ((r_rem != '0) ? 49'sd1 : 49'sd0)) : mag;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

### design/sba_dp.sv
// Datapath: configuration, segment and bin registers, divider, accumulator, output register.
module sba_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [sba_pkg::WL_W-1:0]    i_cfg_data,
    input  sba_pkg::t_cmd               i_cmd,
    output sba_pkg::t_sts               o_sts,
    sba_in_if.sink                      i_in,
    sba_out_if.source                   o_out
);
    logic [sba_pkg::WL_W-1:0]          r_start, r_bw;
    logic [sba_pkg::WL_W-1:0]          r_w, r_pw;
    logic signed [sba_pkg::V_W-1:0]    r_v, r_pv;
    logic                              r_last, r_hp;
    logic [sba_pkg::NB_W-1:0]          r_nb;
    logic signed [sba_pkg::ACC_W-1:0]  r_acc;
    logic [sba_pkg::POS_W-1:0]         r_lo, r_hi, r_ca, r_cb;
    logic signed [sba_pkg::CRV_W-1:0]  r_ia, r_ib;
    logic signed [sba_pkg::V_W-1:0]    r_avg;
    logic                              r_o_valid, r_o_last;
    logic [sba_pkg::BIN_IDX_W-1:0]     r_o_idx;
    logic signed [sba_pkg::V_W-1:0]    r_o_avg;

    logic [sba_pkg::WL_W-1:0]          bw_eff, span, dx, x, pw_clip;
    logic                              seg;
    logic signed [sba_pkg::V_W:0]      dv;
    logic signed [45:0]                prod;
    logic signed [sba_pkg::ACC_W-1:0]  num;
    logic [sba_pkg::WL_W:0]            den;
    logic                              div_busy, div_done;
    logic signed [sba_pkg::QUO_W-1:0]  quo;
    logic signed [sba_pkg::CRV_W-1:0]  crv;
    logic signed [sba_pkg::CRV_W:0]    isum;
    logic [sba_pkg::WL_W-1:0]          cwid;
    logic signed [48:0]                piece;
    logic signed [sba_pkg::V_W-1:0]    sat;
    logic                              out_free;

    assign bw_eff = (r_bw == '0) ? 20'd1 : r_bw;
    assign seg    = r_hp && (r_w > r_pw);
    assign span   = r_w - r_pw;
    assign x      = (i_cmd.div_sel == sba_pkg::DIV_CURVE_A) ? r_ca[sba_pkg::WL_W-1:0]
                                                            : r_cb[sba_pkg::WL_W-1:0];
    assign dx     = x - r_pw;
    assign dv     = (sba_pkg::V_W+1)'(r_v) - (sba_pkg::V_W+1)'(r_pv);
    assign prod   = 46'(dv) * 46'(signed'({1'b0, dx}));
    assign pw_clip = r_pw;

    always_comb begin
        if (i_cmd.div_sel == sba_pkg::DIV_AVG) begin
            num = r_acc + signed'(48'(bw_eff));
            den = {bw_eff, 1'b0};
        end else begin
            num = signed'({prod[45], prod, 1'b0}) + signed'(48'(span));
            den = {span, 1'b0};
        end
    end

    sba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign crv   = sba_pkg::CRV_W'(r_pv) + quo[sba_pkg::CRV_W-1:0];
    assign isum  = (sba_pkg::CRV_W+1)'(r_ia) + (sba_pkg::CRV_W+1)'(r_ib);
    assign cwid  = r_cb[sba_pkg::WL_W-1:0] - r_ca[sba_pkg::WL_W-1:0];
    assign piece = 49'(isum) * 49'(signed'({1'b0, cwid}));

    always_comb begin
        if (quo > sba_pkg::V_MAX) begin
            sat = sba_pkg::V_MAX[sba_pkg::V_W-1:0];
        end else if (quo < sba_pkg::V_MIN) begin
            sat = sba_pkg::V_MIN[sba_pkg::V_W-1:0];
        end else begin
            sat = quo[sba_pkg::V_W-1:0];
        end
    end

    assign out_free = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= sba_pkg::START_RESET;
            r_bw    <= sba_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (sba_pkg::t_cfg_index'(i_cfg_index))
                sba_pkg::CFG_START: r_start <= i_cfg_data;
                sba_pkg::CFG_WIDTH: r_bw    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw      <= '0;
            r_pv      <= '0;
            r_hp      <= 1'b0;
            r_nb      <= '0;
            r_acc     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.acc_add) begin
                r_acc <= r_acc + piece[sba_pkg::ACC_W-1:0];
            end
            if (i_cmd.emit_load) begin
                r_o_valid <= 1'b1;
                r_acc     <= '0;
                r_nb      <= r_nb + 7'd1;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_pw  <= '0;
                    r_pv  <= '0;
                    r_hp  <= 1'b0;
                    r_nb  <= '0;
                    r_acc <= '0;
                end else begin
                    r_pw <= r_w;
                    r_pv <= r_v;
                    r_hp <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_w    <= i_in.wavelength;
            r_v    <= i_in.sample_value;
            r_last <= i_in.last_point;
        end
        if (i_cmd.calc_lo) begin
            r_lo <= sba_pkg::POS_W'(r_start) + sba_pkg::POS_W'(r_nb) * sba_pkg::POS_W'(bw_eff);
        end
        if (i_cmd.calc_hi) begin
            r_hi <= r_lo + sba_pkg::POS_W'(bw_eff);
            r_ca <= (r_lo > sba_pkg::POS_W'(pw_clip)) ? r_lo : sba_pkg::POS_W'(pw_clip);
        end
        if (i_cmd.calc_cb) begin
            r_cb <= (r_hi < sba_pkg::POS_W'(r_w)) ? r_hi : sba_pkg::POS_W'(r_w);
        end
        if (i_cmd.take_ia) begin
            r_ia <= crv;
        end
        if (i_cmd.take_ib) begin
            r_ib <= crv;
        end
        if (i_cmd.take_avg) begin
            r_avg <= sat;
        end
        if (i_cmd.emit_load) begin
            r_o_idx  <= r_nb[sba_pkg::BIN_IDX_W-1:0];
            r_o_avg  <= r_avg;
            r_o_last <= (r_nb == 7'(sba_pkg::BIN_COUNT - 1));
        end
    end

    assign o_sts.bins_done = (r_nb == 7'(sba_pkg::BIN_COUNT));
    assign o_sts.piece_ok  = seg && (r_cb > r_ca);
    assign o_sts.emit_cond = (r_hi <= sba_pkg::POS_W'(r_w)) || r_last;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = out_free;

    assign i_in.ready        = i_cmd.in_ready;
    assign o_out.valid       = r_o_valid;
    assign o_out.bin_index   = r_o_idx;
    assign o_out.bin_average = r_o_avg;
    assign o_out.last_bin    = r_o_last;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_nb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb <= 7'(sba_pkg::BIN_COUNT))
        else $error("bin counter beyond bin count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> out_free)
        else $error("output register overwritten");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_last == (r_o_idx == 6'(sba_pkg::BIN_COUNT - 1))))
        else $error("last bin flag disagrees with bin index");
endmodule

### design/sba_ctrl.sv
// Controller state machine sequencing points, bins and divisions.
module sba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  sba_pkg::t_sts i_sts,
    output sba_pkg::t_cmd o_cmd
);
    sba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = sba_pkg::DIV_CURVE_A;
        unique case (r_state)
            sba_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = sba_pkg::S_BIN;
                end
            end
            sba_pkg::S_BIN: begin
                if (i_sts.bins_done) begin
                    n_state = sba_pkg::S_FINISH;
                end else begin
                    o_cmd.calc_lo = 1'b1;
                    n_state = sba_pkg::S_HI;
                end
            end
            sba_pkg::S_HI: begin
                o_cmd.calc_hi = 1'b1;
                n_state = sba_pkg::S_CLIP;
            end
            sba_pkg::S_CLIP: begin
                o_cmd.calc_cb = 1'b1;
                n_state = sba_pkg::S_PIECE;
            end
            sba_pkg::S_PIECE: begin
                if (i_sts.piece_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state = sba_pkg::S_DIVA;
                end else begin
                    n_state = sba_pkg::S_TEST;
                end
            end
            sba_pkg::S_DIVA: begin
                if (i_sts.div_done) begin
                    o_cmd.take_ia   = 1'b1;
                    o_cmd.div_sel   = sba_pkg::DIV_CURVE_B;
                    o_cmd.div_start = 1'b1;
                    n_state = sba_pkg::S_DIVB;
                end
            end
            sba_pkg::S_DIVB: begin
                if (i_sts.div_done) begin
                    o_cmd.take_ib = 1'b1;
                    n_state = sba_pkg::S_ACC;
                end
            end
            sba_pkg::S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = sba_pkg::S_TEST;
            end
            sba_pkg::S_TEST: begin
                if (i_sts.emit_cond) begin
                    o_cmd.div_sel   = sba_pkg::DIV_AVG;
                    o_cmd.div_start = 1'b1;
                    n_state = sba_pkg::S_DIVAVG;
                end else begin
                    n_state = sba_pkg::S_FINISH;
                end
            end
            sba_pkg::S_DIVAVG: begin
                o_cmd.div_sel = sba_pkg::DIV_AVG;
                if (i_sts.div_done) begin
                    o_cmd.take_avg = 1'b1;
                    n_state = sba_pkg::S_EMIT;
                end
            end
            sba_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = sba_pkg::S_BIN;
                end
            end
            sba_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = sba_pkg::S_IDLE;
            end
            default: begin
                n_state = sba_pkg::S_IDLE;
            end
        endcase
    end
endmodule

### design/spectrum_bin_average_resampler.sv
// Top level of the piecewise-linear spectrum bin-average resampler.
//
//   channel   direction  payload                                  beat when
//   i_in      in         wavelength, sample_value, last_point     valid && ready
//   o_out     out        bin_index, bin_average, last_bin         valid && ready
//   i_cfg_*   in         index 0 start_wavelength, 1 bin_width    i_cfg_we
//
// A point is accepted in the idle state and ends in the finish state. For every bin it closes
// or touches it runs the bin setup states; when the segment overlaps the bin it adds two
// divisions for the two curve values and an accumulate step, and when the bin is
// emitted, a division for the average and a load of the output register. Once all
// bins are out, a point goes straight to the finish state.
// All three divisions share one bit-serial divider (one quotient bit per cycle). One point
// is in work at a time; i_in.ready is high only between points. Reset is synchronous
// and active low and restores the register defaults. A stalled output holds its beat
// in the output register and the block waits there before emitting the next bin.
module spectrum_bin_average_resampler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [sba_pkg::WL_W-1:0]  i_cfg_data,
    sba_in_if.sink                    i_in,
    sba_out_if.source                 o_out
);
    sba_pkg::t_cmd cmd;
    sba_pkg::t_sts sts;

    // The controller only sequences; every value lives in the datapath.
    sba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out       (o_out)
    );
endmodule

### dv/tb_spectrum_bin_average_resampler.sv
// Self-checking testbench of the spectrum bin-average resampler.
module tb_spectrum_bin_average_resampler;

    // One expected output beat.
    typedef struct {
        logic [sba_pkg::BIN_IDX_W-1:0]    index;
        logic signed [sba_pkg::V_W-1:0]   average;
        logic                             is_final;
    } t_bin_beat;

    // How a directed row is checked: by the bin model, by a result typed in, or not at all.
    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_ALL_ZERO,
        ROW_NONE
    } t_row_kind;

    typedef struct {
        logic [sba_pkg::WL_W-1:0]         wavelength;
        logic signed [sba_pkg::V_W-1:0]   sample_value;
        logic                             last_point;
        t_row_kind                        kind;
    } t_point_row;

    localparam int SETTLE_CYCLES   = 400;
    localparam int HOLD_CYCLES     = 3000;
    localparam int PHASE_POINTS    = 51;
    localparam int PHASE_COUNT     = 8;
    localparam longint WL_TOP      = 1048575;
    localparam longint VAL_TOP     = 8388607;
    localparam longint VAL_BOTTOM  = -8388608;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [sba_pkg::WL_W-1:0] i_cfg_data;

    sba_in_if  point_ch ();
    sba_out_if bin_ch ();

    spectrum_bin_average_resampler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (point_ch),
        .o_out       (bin_ch)
    );

    // Model copy of the block: registers and spectrum state.
    longint mdl_start;
    longint mdl_width;
    longint mdl_prev_wl;
    longint mdl_prev_val;
    bit     mdl_have_prev;
    int     mdl_next_bin;
    longint mdl_acc;

    t_bin_beat bins_expected[$];
    int  error_count;
    int  bins_checked;
    int  points_sent;
    int  spectra_sent;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    logic hold_out;

    // The clock runs with a period of two time units.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The run is cut off after a generous fixed time, well past the slowest correct run.
    initial begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    // Division that rounds toward minus infinity, as the block's arithmetic requires.
    function automatic longint div_floor(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    // Curve value at x on the segment (wa, va) - (wb, vb), rounded half up.
    function automatic longint curve_value(input longint wa, input longint va,
                                           input longint wb, input longint vb,
                                           input longint x);
        longint span;
        span = wb - wa;
        return va + div_floor(2 * (vb - va) * (x - wa) + span, 2 * span);
    endfunction

    // Advances the model by one point and, where asked, queues the bins it closes.
    task automatic predict_bins(input logic [sba_pkg::WL_W-1:0] wl_in,
                                input logic signed [sba_pkg::V_W-1:0] val_in,
                                input logic last_in, input bit queue_them);
        longint wl, val, bw, lo, hi, ca, cb, ia, ib, avg;
        bit seg;
        t_bin_beat beat;
        wl  = wl_in;
        val = val_in;
        bw  = (mdl_width == 0) ? 1 : mdl_width;
        seg = mdl_have_prev && (wl > mdl_prev_wl);
        while (mdl_next_bin < sba_pkg::BIN_COUNT) begin
            lo = mdl_start + mdl_next_bin * bw;
            hi = lo + bw;
            if (seg) begin
                ca = (lo > mdl_prev_wl) ? lo : mdl_prev_wl;
                cb = (hi < wl) ? hi : wl;
                if (cb > ca) begin
                    ia = curve_value(mdl_prev_wl, mdl_prev_val, wl, val, ca);
                    ib = curve_value(mdl_prev_wl, mdl_prev_val, wl, val, cb);
                    mdl_acc = mdl_acc + (ia + ib) * (cb - ca);
                end
            end
            if (!(hi <= wl || last_in)) break;
            avg = div_floor(mdl_acc + bw, 2 * bw);
            if (avg > VAL_TOP) avg = VAL_TOP;
            if (avg < VAL_BOTTOM) avg = VAL_BOTTOM;
            beat.index    = mdl_next_bin[sba_pkg::BIN_IDX_W-1:0];
            beat.average  = avg[sba_pkg::V_W-1:0];
            beat.is_final = (mdl_next_bin == sba_pkg::BIN_COUNT - 1);
            if (queue_them) bins_expected.insert(bins_expected.size(), beat);
            mdl_acc      = 0;
            mdl_next_bin = mdl_next_bin + 1;
        end
        if (last_in) begin
            mdl_prev_wl   = 0;
            mdl_prev_val  = 0;
            mdl_have_prev = 0;
            mdl_next_bin  = 0;
            mdl_acc       = 0;
        end else begin
            mdl_prev_wl   = wl;
            mdl_prev_val  = val;
            mdl_have_prev = 1;
        end
    endtask

    // Offers one point, waits for its beat, then updates the model. Called just after
    // a rising edge; returns just after the edge that accepted the point.
    task automatic send_point(input logic [sba_pkg::WL_W-1:0] wl,
                              input logic signed [sba_pkg::V_W-1:0] val,
                              input logic last_in, input t_row_kind kind);
        t_bin_beat beat;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            point_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        point_ch.valid        <= 1'b1;
        point_ch.wavelength   <= wl;
        point_ch.sample_value <= val;
        point_ch.last_point   <= last_in;
        do @(posedge i_clk); while (!point_ch.ready);
        points_sent = points_sent + 1;
        if (last_in) spectra_sent = spectra_sent + 1;
        predict_bins(wl, val, last_in, kind == ROW_MODEL);
        // A lone point right after reset closes every bin with a zero average.
        if (kind == ROW_ALL_ZERO) begin
            for (int b = 0; b < sba_pkg::BIN_COUNT; b++) begin
                beat.index    = b[sba_pkg::BIN_IDX_W-1:0];
                beat.average  = '0;
                beat.is_final = (b == sba_pkg::BIN_COUNT - 1);
                bins_expected.insert(bins_expected.size(), beat);
            end
        end
    endtask

    // Lets the block drain and finish any point still in work, so registers can change.
    task automatic wait_until_quiet();
        point_ch.valid <= 1'b0;
        while (bins_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drives one register write for one cycle; the caller drops the write enable.
    task automatic write_register(input logic index, input logic [sba_pkg::WL_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (index == sba_pkg::CFG_START) mdl_start = data;
        else mdl_width = data;
    endtask

    // Receiver: random stalls, plus one long hold-off counted here while points keep coming.
    initial begin
        hold_out = 1'b0;
        wait (hold_request);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    always @(posedge i_clk) begin
        bin_ch.ready <= !hold_out && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Output checker: every accepted beat is matched with the oldest expected bin.
    always @(posedge i_clk) begin
        if (i_rst_n && bin_ch.valid && bin_ch.ready) begin
            if (bins_expected.size() == 0) begin
                $error("unexpected bin beat: bin_index %0d", bin_ch.bin_index);
                error_count = error_count + 1;
            end else begin
                t_bin_beat want;
                want = bins_expected.pop_front();
                bins_checked = bins_checked + 1;
                if (bin_ch.bin_index !== want.index) begin
                    $error("bin_index: expected %0d, actual %0d", want.index, bin_ch.bin_index);
                    error_count = error_count + 1;
                end
                if (bin_ch.bin_average !== want.average) begin
                    $error("bin_average: expected %0d, actual %0d",
                           want.average, bin_ch.bin_average);
                    error_count = error_count + 1;
                end
                if (bin_ch.last_bin !== want.is_final) begin
                    $error("last_bin: expected %0d, actual %0d", want.is_final, bin_ch.last_bin);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Directed points, under the reset register values (bins from 97280 to 199680).
    t_point_row directed_rows[] = '{
        '{20'd100000, 24'sd1000,     1'b1, ROW_ALL_ZERO},
        '{20'd0,      24'sd8388607,  1'b0, ROW_MODEL},
        '{20'd1048575, -24'sd8388608, 1'b1, ROW_MODEL},
        '{20'd97280,  24'sd65536,    1'b0, ROW_MODEL},
        '{20'd97280,  24'sd0,        1'b0, ROW_MODEL},
        '{20'd98880,  -24'sd65536,   1'b0, ROW_MODEL},
        '{20'd98000,  24'sd5,        1'b0, ROW_MODEL},
        '{20'd150000, 24'sd8388607,  1'b0, ROW_MODEL},
        '{20'd199680, -24'sd8388608, 1'b0, ROW_MODEL},
        '{20'd199700, 24'sd1,        1'b0, ROW_MODEL},
        '{20'd200000, 24'sd3,        1'b1, ROW_NONE},
        '{20'd120000, -24'sd8388608, 1'b0, ROW_MODEL},
        '{20'd150000, 24'sd8388607,  1'b1, ROW_MODEL},
        '{20'd98001,  24'sd4660,     1'b0, ROW_MODEL},
        '{20'd98001,  -24'sd1,       1'b1, ROW_MODEL}
    };

    // Register settings of the random phases; a zero width acts as width one.
    longint phase_start[PHASE_COUNT] = '{97280, 0, 1048575, 0, 200000, 1000, 5000, 0};
    longint phase_width[PHASE_COUNT] = '{1600, 1, 1048575, 0, 16384, 100, 7, 0};

    initial begin
        longint wl, val, bw, step;
        int     phase_points, len;
        logic   is_last;
        error_count    = 0;
        bins_checked   = 0;
        points_sent    = 0;
        spectra_sent   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        mdl_start      = sba_pkg::START_RESET;
        mdl_width      = sba_pkg::WIDTH_RESET;
        mdl_prev_wl    = 0;
        mdl_prev_val   = 0;
        mdl_have_prev  = 0;
        mdl_next_bin   = 0;
        mdl_acc        = 0;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_index           <= sba_pkg::CFG_START;
        i_cfg_data            <= '0;
        point_ch.valid        <= 1'b0;
        point_ch.wavelength   <= '0;
        point_ch.sample_value <= '0;
        point_ch.last_point   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, back to back and without stalls.
        foreach (directed_rows[r])
            send_point(directed_rows[r].wavelength, directed_rows[r].sample_value,
                       directed_rows[r].last_point, directed_rows[r].kind);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_until_quiet();
            // The last two phases take random register values.
            if (p >= 6) begin
                phase_start[p] = $urandom_range(0, 1048575);
                phase_width[p] = (p == 6) ? $urandom_range(1, 4000)
                                          : $urandom_range(1, 1048575);
            end
            write_register(sba_pkg::CFG_START, phase_start[p][sba_pkg::WL_W-1:0]);
            write_register(sba_pkg::CFG_WIDTH, phase_width[p][sba_pkg::WL_W-1:0]);
            i_cfg_we <= 1'b0;
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            // The long receiver hold-off falls in the first random phase.
            if (p == 0) hold_request = 1;

            bw = (mdl_width == 0) ? 1 : mdl_width;
            phase_points = 0;
            while (phase_points < PHASE_POINTS) begin
                // Most spectra start somewhat below the first bin and walk upward.
                len = $urandom_range(3, 18);
                wl  = mdl_start - $urandom_range(0, 2) * bw;
                if (wl < 0) wl = 0;
                val = $signed($urandom_range(0, 16777215)) >>> 8;
                for (int k = 0; k < len; k++) begin
                    is_last = (k == len - 1);
                    if ($urandom_range(0, 9) == 0) begin
                        // Noise: anywhere in the field ranges, possibly descending.
                        send_point(sba_pkg::WL_W'($urandom_range(0, 1048575)),
                                   sba_pkg::V_W'($urandom_range(0, 16777215)),
                                   is_last, ROW_MODEL);
                    end else begin
                        if ($urandom_range(0, 1)) val = $signed($urandom() << 8) >>> 8;
                        else val = val + $signed($urandom_range(0, 65535)) - 32768;
                        if (val > VAL_TOP) val = VAL_TOP;
                        if (val < VAL_BOTTOM) val = VAL_BOTTOM;
                        send_point(wl[sba_pkg::WL_W-1:0], val[sba_pkg::V_W-1:0],
                                   is_last, ROW_MODEL);
                        step = $urandom_range(0, 7) * bw / 2 + $urandom_range(0, 3);
                        wl = wl + step;
                        if (wl > WL_TOP) wl = WL_TOP;
                    end
                    phase_points = phase_points + 1;
                end
            end
        end

        point_ch.valid <= 1'b0;
        while (bins_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d points in %0d spectra over %0d register settings.",
                 points_sent, spectra_sent, PHASE_COUNT + 1);
        $display("Checked %0d bin beats, %0d mismatches.", bins_checked, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
design/sba_pkg.sv
design/sba_if.sv
design/sba_div.sv
design/sba_dp.sv
design/sba_ctrl.sv
design/spectrum_bin_average_resampler.sv
dv/tb_spectrum_bin_average_resampler.sv
